>>> sv/sd_mmc_card_identification_unit_defines.svh
// ----------------------------------------------------------------------------
// SD/MMC card identification unit: assertion macros
// Shared assertion macros for the checker of the identification unit.
// ----------------------------------------------------------------------------
`ifndef SD_MMC_CARD_IDENTIFICATION_UNIT_DEFINES_SVH
`define SD_MMC_CARD_IDENTIFICATION_UNIT_DEFINES_SVH

// Clocked property that is switched off while reset is asserted.
`define SDID_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Clocked property that also holds during reset.
`define SDID_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) expr) else $error(msg);

`endif

>>> sv/sdid_pkg.sv
// ----------------------------------------------------------------------------
// SD/MMC card identification package
// Word types, configuration types and command constants of the unit.
// ----------------------------------------------------------------------------
package sdid_pkg;

    typedef struct packed {
        logic        action;
        logic        timed_out;
        logic        crc_failed;
        logic [31:0] response_word;
    } in_t;

    typedef struct packed {
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic        expect_response;
        logic        long_response;
        logic        check_crc;
        logic        wait_before;
        logic        finished;
        logic        succeeded;
        logic [2:0]  card_type;
        logic [15:0] card_address;
    } out_t;

    typedef struct packed {
        logic [23:0] voltage_window;
        logic [7:0]  op_retry_limit;
    } cfg_t;

    // Configuration register indexes.
    localparam logic CFG_VOLTAGE_WINDOW = 1'b0;
    localparam logic CFG_OP_RETRY_LIMIT = 1'b1;

    localparam logic [23:0] VOLTAGE_WINDOW_RST = 24'h20_0000;
    localparam logic [7:0]  OP_RETRY_LIMIT_RST = 8'd100;

    // Action codes.
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // Command indexes.
    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_SEND_OP_MMC  = 6'd1;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SET_RCA      = 6'd3;
    localparam logic [5:0] CMD_SELECT       = 6'd7;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
    localparam logic [5:0] ACMD_SD_SEND_OP  = 6'd41;
    localparam logic [5:0] CMD_APP_CMD      = 6'd55;

    // Card kinds.
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_MMC  = 3'd1;
    localparam logic [2:0] KIND_SD   = 3'd2;
    localparam logic [2:0] KIND_SD2  = 3'd3;
    localparam logic [2:0] KIND_SDHC = 3'd4;

    localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
    localparam logic [7:0]  IF_COND_ECHO = 8'hAA;
    localparam logic [31:0] HCS_BIT      = 32'h4000_0000;
    localparam int          READY_POS    = 31;
    localparam int          HCS_POS      = 30;
    localparam int          ILLEGAL_POS  = 22;
    localparam int          APP_CMD_POS  = 5;
    localparam logic [15:0] MMC_RCA      = 16'h0001;

endpackage

>>> sv/sdid_seq.sv
// ----------------------------------------------------------------------------
// SD/MMC card identification sequencer
// Holds the sequence state and turns one word into the next command.
// ----------------------------------------------------------------------------
module sdid_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  sdid_pkg::in_t item,
    input  sdid_pkg::cfg_t cfg,
    output logic          res_valid,
    output sdid_pkg::out_t res
);
    import sdid_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_RSTA,
        PH_RSTB,
        PH_IFC,
        PH_RSTC,
        PH_APP,
        PH_SOP,
        PH_RSTD,
        PH_MOP,
        PH_CID,
        PH_RCA,
        PH_CSD,
        PH_SEL,
        PH_DESEL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  attempts_reg, attempts_next;
    logic        retried_reg, retried_next;

    logic        crc_checked;
    logic        ok;
    logic [7:0]  attempts_inc;
    logic        limit_hit;
    logic [31:0] op_window;
    logic        app_ok;
    logic        op_ready;

    assign crc_checked = (phase_reg == PH_IFC) || (phase_reg == PH_CID) ||
                         (phase_reg == PH_RCA) || (phase_reg == PH_CSD) ||
                         (phase_reg == PH_SEL) || (phase_reg == PH_DESEL);
    assign ok           = !item.timed_out && !(item.crc_failed && crc_checked);
    assign attempts_inc = attempts_reg + 8'd1;
    assign limit_hit    = (attempts_inc >= cfg.op_retry_limit);
    assign op_window    = {8'd0, cfg.voltage_window};
    assign app_ok       = ok && !item.response_word[ILLEGAL_POS]
                             && item.response_word[APP_CMD_POS];
    assign op_ready     = ok && item.response_word[READY_POS];

    always_comb
    begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        attempts_next = attempts_reg;
        retried_next  = retried_reg;
        res_valid     = 1'b1;
        res           = '0;

        if (item.action == ACT_START)
        begin
            kind_next     = KIND_NONE;
            addr_next     = '0;
            attempts_next = '0;
            retried_next  = 1'b0;
            phase_next    = PH_RSTA;
            res.cmd_index = CMD_GO_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_RSTA, PH_RSTB, PH_RSTC, PH_RSTD:
                begin
                    if (!ok)
                    begin
                        if (!retried_reg)
                        begin
                            // First failure of a reset: repeat it after a wait.
                            retried_next    = 1'b1;
                            res.cmd_index   = CMD_GO_IDLE;
                            res.wait_before = 1'b1;
                        end
                        else if (phase_reg == PH_RSTB)
                        begin
                            retried_next  = 1'b0;
                            phase_next    = PH_RSTC;
                            res.cmd_index = CMD_GO_IDLE;
                        end
                        else if (phase_reg == PH_RSTC)
                        begin
                            retried_next  = 1'b0;
                            phase_next    = PH_RSTD;
                            res.cmd_index = CMD_GO_IDLE;
                        end
                        else
                        begin
                            phase_next   = PH_IDLE;
                            res.finished = 1'b1;
                        end
                    end
                    else
                    begin
                        retried_next = 1'b0;
                        if (phase_reg == PH_RSTA)
                        begin
                            phase_next    = PH_RSTB;
                            res.cmd_index = CMD_GO_IDLE;
                        end
                        else if (phase_reg == PH_RSTB)
                        begin
                            phase_next          = PH_IFC;
                            res.cmd_index       = CMD_SEND_IF_COND;
                            res.cmd_argument    = IF_COND_ARG;
                            res.expect_response = 1'b1;
                            res.check_crc       = 1'b1;
                        end
                        else
                        begin
                            attempts_next = '0;
                            if (cfg.op_retry_limit == 8'd0)
                            begin
                                kind_next = KIND_NONE;
                                if (phase_reg == PH_RSTC)
                                begin
                                    phase_next    = PH_RSTD;
                                    res.cmd_index = CMD_GO_IDLE;
                                end
                                else
                                begin
                                    phase_next   = PH_IDLE;
                                    res.finished = 1'b1;
                                end
                            end
                            else if (phase_reg == PH_RSTC)
                            begin
                                phase_next          = PH_APP;
                                res.cmd_index       = CMD_APP_CMD;
                                res.expect_response = 1'b1;
                            end
                            else
                            begin
                                phase_next          = PH_MOP;
                                res.cmd_index       = CMD_SEND_OP_MMC;
                                res.cmd_argument    = op_window | HCS_BIT;
                                res.expect_response = 1'b1;
                            end
                        end
                    end
                end

                PH_IFC:
                begin
                    kind_next = (ok && item.response_word[7:0] == IF_COND_ECHO) ?
                                KIND_SD2 : KIND_NONE;
                    retried_next  = 1'b0;
                    phase_next    = PH_RSTC;
                    res.cmd_index = CMD_GO_IDLE;
                end

                PH_APP, PH_SOP:
                begin
                    if (phase_reg == PH_APP && app_ok)
                    begin
                        phase_next          = PH_SOP;
                        res.cmd_index       = ACMD_SD_SEND_OP;
                        res.cmd_argument    = op_window |
                                              ((kind_reg == KIND_SD2) ? HCS_BIT : '0);
                        res.expect_response = 1'b1;
                    end
                    else if (phase_reg == PH_SOP && op_ready)
                    begin
                        if (item.response_word[HCS_POS])
                            kind_next = KIND_SDHC;
                        else if (kind_reg != KIND_SD2)
                            kind_next = KIND_SD;
                        phase_next          = PH_CID;
                        res.cmd_index       = CMD_ALL_SEND_CID;
                        res.expect_response = 1'b1;
                        res.long_response   = 1'b1;
                        res.check_crc       = 1'b1;
                    end
                    else
                    begin
                        // Failed SD poll: retry or fall back to MMC.
                        attempts_next = attempts_inc;
                        if (limit_hit)
                        begin
                            kind_next     = KIND_NONE;
                            retried_next  = 1'b0;
                            phase_next    = PH_RSTD;
                            res.cmd_index = CMD_GO_IDLE;
                        end
                        else
                        begin
                            phase_next          = PH_APP;
                            res.cmd_index       = CMD_APP_CMD;
                            res.expect_response = 1'b1;
                        end
                    end
                end

                PH_MOP:
                begin
                    if (op_ready)
                    begin
                        kind_next           = KIND_MMC;
                        phase_next          = PH_CID;
                        res.cmd_index       = CMD_ALL_SEND_CID;
                        res.expect_response = 1'b1;
                        res.long_response   = 1'b1;
                        res.check_crc       = 1'b1;
                    end
                    else
                    begin
                        attempts_next = attempts_inc;
                        if (limit_hit)
                        begin
                            kind_next    = KIND_NONE;
                            phase_next   = PH_IDLE;
                            res.finished = 1'b1;
                        end
                        else
                        begin
                            res.cmd_index       = CMD_SEND_OP_MMC;
                            res.cmd_argument    = op_window | HCS_BIT;
                            res.expect_response = 1'b1;
                        end
                    end
                end

                PH_CID:
                begin
                    if (ok && kind_reg == KIND_MMC)
                    begin
                        addr_next           = MMC_RCA;
                        phase_next          = PH_RCA;
                        res.cmd_index       = CMD_SET_RCA;
                        res.cmd_argument    = {MMC_RCA, 16'd0};
                        res.expect_response = 1'b1;
                        res.check_crc       = 1'b1;
                    end
                    else if (ok && (kind_reg == KIND_SD || kind_reg == KIND_SD2 ||
                                    kind_reg == KIND_SDHC))
                    begin
                        phase_next          = PH_RCA;
                        res.cmd_index       = CMD_SET_RCA;
                        res.expect_response = 1'b1;
                        res.check_crc       = 1'b1;
                    end
                    else
                    begin
                        // A card without a known kind loses its address too.
                        if (ok)
                            addr_next = '0;
                        phase_next   = PH_IDLE;
                        res.finished = 1'b1;
                    end
                end

                PH_RCA:
                begin
                    if (!ok)
                    begin
                        phase_next   = PH_IDLE;
                        res.finished = 1'b1;
                    end
                    else
                    begin
                        if (kind_reg != KIND_MMC)
                            addr_next = item.response_word[31:16];
                        phase_next          = PH_CSD;
                        res.cmd_index       = CMD_SEND_CSD;
                        res.cmd_argument    = {addr_next, 16'd0};
                        res.expect_response = 1'b1;
                        res.long_response   = 1'b1;
                        res.check_crc       = 1'b1;
                    end
                end

                PH_CSD:
                begin
                    if (!ok)
                    begin
                        phase_next   = PH_IDLE;
                        res.finished = 1'b1;
                    end
                    else
                    begin
                        phase_next          = PH_SEL;
                        res.cmd_index       = CMD_SELECT;
                        res.cmd_argument    = {addr_reg, 16'd0};
                        res.expect_response = 1'b1;
                        res.check_crc       = 1'b1;
                    end
                end

                PH_SEL:
                begin
                    if (!ok)
                    begin
                        phase_next   = PH_IDLE;
                        res.finished = 1'b1;
                    end
                    else
                    begin
                        phase_next          = PH_DESEL;
                        res.cmd_index       = CMD_SELECT;
                        res.expect_response = 1'b1;
                        res.check_crc       = 1'b1;
                    end
                end

                PH_DESEL:
                begin
                    phase_next    = PH_IDLE;
                    res.finished  = 1'b1;
                    res.succeeded = ok;
                end

                default:
                begin
                    // Completion with no sequence running is dropped.
                    phase_next = PH_IDLE;
                    res_valid  = 1'b0;
                end
            endcase
        end

        res.card_type    = kind_next;
        res.card_address = addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            kind_reg     <= KIND_NONE;
            addr_reg     <= '0;
            attempts_reg <= '0;
            retried_reg  <= 1'b0;
        end
        else if (go)
        begin
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            addr_reg     <= addr_next;
            attempts_reg <= attempts_next;
            retried_reg  <= retried_next;
        end
    end

endmodule

>>> sv/sd_mmc_card_identification_unit.sv
// Path: a word is registered on entry, and its result word is then loaded into the output
// register whenever the output register is empty or being read.
// Throughput: one word per cycle unless the output register is stalled; the sequence state updates in a single pass.
// Reset: rst_n clears both stages, the sequence state (idle, no card, address 0)
// and loads the voltage window 0x200000 and the op-condition poll limit 100.
// ----------------------------------------------------------------------------
// SD/MMC card identification unit
// Input register, identification sequencer and output register.
// ----------------------------------------------------------------------------
module sd_mmc_card_identification_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sdid_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output sdid_pkg::out_t  out_data,
    input  logic            cfg_wr_en,
    input  logic            cfg_index,
    input  logic [23:0]     cfg_data
);
    import sdid_pkg::*;

    cfg_t cfg_reg;
    logic s1_valid_reg, s1_valid_next;
    in_t  s1_data_reg;
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;

    logic advance;
    logic in_fire;
    logic go;
    logic res_valid;
    out_t res;

    // The entry stage moves on whenever the output register is empty or being read.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;
    assign go       = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (go && res_valid)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    sdid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .item      (s1_data_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            cfg_reg.voltage_window <= VOLTAGE_WINDOW_RST;
            cfg_reg.op_retry_limit <= OP_RETRY_LIMIT_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_VOLTAGE_WINDOW: cfg_reg.voltage_window <= cfg_data;
                    CFG_OP_RETRY_LIMIT: cfg_reg.op_retry_limit <= cfg_data[7:0];
                    default:            cfg_reg                <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_data_reg <= in_data;
        if (go && res_valid)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/sdid_checker.sv
// ----------------------------------------------------------------------------
// SD/MMC card identification checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "sd_mmc_card_identification_unit_defines.svh"

module sdid_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input sdid_pkg::out_t out_data
);
    import sdid_pkg::*;

    `SDID_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result word changed")

    `SDID_ASSERT(a_fin_quiet, out_valid && out_data.finished |-> out_data.cmd_index == CMD_GO_IDLE && out_data.cmd_argument == '0 && !out_data.expect_response && !out_data.long_response && !out_data.check_crc && !out_data.wait_before, "finished word carries a command")

    `SDID_ASSERT(a_ok_card, out_valid && out_data.succeeded |-> out_data.finished && out_data.card_type != KIND_NONE, "success without a finished sequence or a card")

    `SDID_ASSERT_ALWAYS(a_wait_reset, out_valid && out_data.wait_before |-> out_data.cmd_index == CMD_GO_IDLE && !out_data.finished, "wait requested on a command other than a reset")

endmodule

bind sd_mmc_card_identification_unit sdid_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
